@@ sv/utciv_pkg.sv @@
// ----------------------------------------------------------------------------
// utciv_pkg
// Shared types, constants and small helpers for the timestamp-to-civil block.
// ----------------------------------------------------------------------------
`default_nettype none

package utciv_pkg;

   localparam int TS_W = 33;

   // csr register indexes
   localparam logic [1:0] CSR_MIN_TIMESTAMP = 2'd0;
   localparam logic [1:0] CSR_MAX_TIMESTAMP = 2'd1;

   localparam logic [TS_W-1:0] MIN_TS_RESET = 33'd946684800;
   localparam logic [TS_W-1:0] MAX_TS_RESET = 33'd4102444799;

   // reciprocals: floor(x/d) = (x*R) >> S over the stated input range
   localparam logic [26:0] DAY_RECIP   = 27'd101806633; // /675, x < 2^26
   localparam int          DAY_SHIFT   = 36;
   localparam logic [17:0] HOUR_RECIP  = 18'd149131;    // /3600, x < 86400
   localparam int          HOUR_SHIFT  = 29;
   localparam logic [12:0] MIN_RECIP   = 13'd4370;      // /60, x < 4096
   localparam int          MIN_SHIFT   = 18;
   localparam logic [16:0] Q365S_RECIP = 17'd91930;     // /365, x < 2^16
   localparam int          Q365S_SHIFT = 25;
   localparam logic [18:0] Q365L_RECIP = 19'd367720;    // /365, x < 2^18
   localparam int          Q365L_SHIFT = 27;
   localparam logic [11:0] MP_RECIP    = 12'd3427;      // /153, x < 2048
   localparam int          MP_SHIFT    = 19;

   localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
   localparam logic [19:0] DAYS_SHIFT    = 20'd719468;
   localparam logic [19:0] DAYS_PER_ERA  = 20'd146097;
   localparam logic [17:0] DAYS_4C_M1    = 18'd146096;
   localparam logic [17:0] DAYS_1C       = 18'd36524;
   localparam logic [16:0] SECS_PER_HOUR = 17'd3600;
   localparam logic [11:0] BASE_YEAR     = 12'd2000;

   typedef struct packed {
      logic       valid_res;
      logic [7:0] year_offset;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } civil_res_type;

   // era index for day counts below 6 eras
   function automatic logic [2:0] era_of(input logic [19:0] dd);
      logic [2:0] e;
      e = 3'd0;
      for (int k = 1; k <= 5; k++) begin
         if (dd >= 20'(k) * DAYS_PER_ERA) begin
            e = 3'(k);
         end
      end
      return e;
   endfunction

   // doe / 36524 for doe <= 146096
   function automatic logic [2:0] cent_of(input logic [17:0] doe);
      logic [2:0] c;
      c = 3'd0;
      for (int k = 1; k <= 4; k++) begin
         if (doe >= 18'(k) * DAYS_1C) begin
            c = 3'(k);
         end
      end
      return c;
   endfunction

   // yoe / 100 for yoe < 400
   function automatic logic [1:0] div100(input logic [8:0] yoe);
      logic [1:0] c;
      c = 2'd0;
      for (int k = 1; k <= 3; k++) begin
         if (yoe >= 9'(k * 100)) begin
            c = 2'(k);
         end
      end
      return c;
   endfunction

   // (153*mp + 2) / 5, day of a March-based year where month mp starts
   function automatic logic [8:0] month_start(input logic [3:0] mp);
      logic [8:0] s;
      unique case (mp)
         4'd0:    s = 9'd0;
         4'd1:    s = 9'd31;
         4'd2:    s = 9'd61;
         4'd3:    s = 9'd92;
         4'd4:    s = 9'd122;
         4'd5:    s = 9'd153;
         4'd6:    s = 9'd184;
         4'd7:    s = 9'd214;
         4'd8:    s = 9'd245;
         4'd9:    s = 9'd275;
         4'd10:   s = 9'd306;
         4'd11:   s = 9'd337;
         default: s = 9'd0;
      endcase
      return s;
   endfunction

endpackage

`default_nettype wire

@@ sv/utciv_pipe.sv @@
// ----------------------------------------------------------------------------
// utciv_pipe
// Eight-stage datapath: day split, era, year of era, day of year, month/day,
// and hh:mm:ss alongside. All stages advance together on en.
// ----------------------------------------------------------------------------
`default_nettype none

module utciv_pipe
   import utciv_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_valid,
   input  wire logic [TS_W-1:0]     in_ts,
   input  wire logic [TS_W-1:0]     min_ts,
   input  wire logic [TS_W-1:0]     max_ts,
   output logic                     out_valid,
   output civil_res_type            out_res
);

   typedef struct packed {
      logic [TS_W-1:0] ts;
   } st_a_type;

   typedef struct packed {
      logic        win;
      logic [16:0] days;
      logic [16:0] ts_lo;
   } st_b_type;

   typedef struct packed {
      logic        win;
      logic [19:0] dd;
      logic [16:0] sod;
   } st_c_type;

   typedef struct packed {
      logic        win;
      logic [17:0] doe;
      logic [2:0]  era;
      logic [16:0] sod;
      logic [4:0]  hours;
   } st_d_type;

   typedef struct packed {
      logic        win;
      logic [17:0] n;
      logic [17:0] doe;
      logic [2:0]  era;
      logic [11:0] rh;
      logic [4:0]  hours;
   } st_e_type;

   typedef struct packed {
      logic        win;
      logic [8:0]  yoe;
      logic [17:0] doe;
      logic [2:0]  era;
      logic [11:0] rh;
      logic [4:0]  hours;
      logic [5:0]  minutes;
   } st_f_type;

   typedef struct packed {
      logic        win;
      logic [8:0]  doy;
      logic [11:0] year;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } st_g_type;

   typedef struct packed {
      logic        win;
      logic [3:0]  mp;
      logic [8:0]  doy;
      logic [11:0] year;
      logic [4:0]  hours;
      logic [5:0]  minutes;
      logic [5:0]  seconds;
   } st_h_type;

   logic [7:0] vld_ff, vld_in;
   st_a_type   a_ff, a_in;
   st_b_type   b_ff, b_in;
   st_c_type   c_ff, c_in;
   st_d_type   d_ff, d_in;
   st_e_type   e_ff, e_in;
   st_f_type   f_ff, f_in;
   st_g_type   g_ff, g_in;
   st_h_type   h_ff, h_in;

   logic [52:0] day_prod;
   logic [34:0] hour_prod;
   logic [32:0] q1460_prod;
   logic [36:0] yoe_prod;
   logic [24:0] min_prod;
   logic [10:0] mp_arg;
   logic [22:0] mp_prod;
   logic [17:0] doy_full;
   logic [16:0] rh_full;
   logic [11:0] sec_full;
   logic [3:0]  mon;
   logic [11:0] year_adj;
   logic [8:0]  dom_full;

   assign vld_in = {vld_ff[6:0], in_valid};

   always_comb begin
      a_in.ts = in_ts;
   end

   always_comb begin
      day_prod   = 53'(a_ff.ts[TS_W-1:7]) * 53'(DAY_RECIP);
      b_in.win   = (a_ff.ts >= min_ts) && (a_ff.ts <= max_ts);
      b_in.days  = day_prod[DAY_SHIFT +: 17];
      b_in.ts_lo = a_ff.ts[16:0];
   end

   always_comb begin
      c_in.win = b_ff.win;
      c_in.sod = b_ff.ts_lo - b_ff.days * SECS_PER_DAY;
      c_in.dd  = 20'(b_ff.days) + DAYS_SHIFT;
   end

   always_comb begin
      hour_prod  = 35'(c_ff.sod) * 35'(HOUR_RECIP);
      d_in.win   = c_ff.win;
      d_in.era   = era_of(c_ff.dd);
      d_in.doe   = 18'(c_ff.dd - 20'(d_in.era) * DAYS_PER_ERA);
      d_in.sod   = c_ff.sod;
      d_in.hours = hour_prod[HOUR_SHIFT +: 5];
   end

   always_comb begin
      q1460_prod = 33'(d_ff.doe[17:2]) * 33'(Q365S_RECIP);
      rh_full    = d_ff.sod - 17'(d_ff.hours) * SECS_PER_HOUR;
      e_in.win   = d_ff.win;
      e_in.n     = d_ff.doe - 18'(q1460_prod[Q365S_SHIFT +: 7])
                   + 18'(cent_of(d_ff.doe))
                   - 18'(d_ff.doe == DAYS_4C_M1);
      e_in.doe   = d_ff.doe;
      e_in.era   = d_ff.era;
      e_in.rh    = rh_full[11:0];
      e_in.hours = d_ff.hours;
   end

   always_comb begin
      yoe_prod     = 37'(e_ff.n) * 37'(Q365L_RECIP);
      min_prod     = 25'(e_ff.rh) * 25'(MIN_RECIP);
      f_in.win     = e_ff.win;
      f_in.yoe     = yoe_prod[Q365L_SHIFT +: 9];
      f_in.doe     = e_ff.doe;
      f_in.era     = e_ff.era;
      f_in.rh      = e_ff.rh;
      f_in.hours   = e_ff.hours;
      f_in.minutes = min_prod[MIN_SHIFT +: 6];
   end

   always_comb begin
      doy_full     = f_ff.doe - (18'(f_ff.yoe) * 18'd365 + 18'(f_ff.yoe[8:2])
                     - 18'(div100(f_ff.yoe)));
      sec_full     = f_ff.rh - 12'(f_ff.minutes) * 12'd60;
      g_in.win     = f_ff.win;
      g_in.doy     = doy_full[8:0];
      g_in.year    = 12'(f_ff.yoe) + 12'(f_ff.era) * 12'd400;
      g_in.hours   = f_ff.hours;
      g_in.minutes = f_ff.minutes;
      g_in.seconds = sec_full[5:0];
   end

   always_comb begin
      mp_arg       = 11'(g_ff.doy) * 11'd5 + 11'd2;
      mp_prod      = 23'(mp_arg) * 23'(MP_RECIP);
      h_in.win     = g_ff.win;
      h_in.mp      = mp_prod[MP_SHIFT +: 4];
      h_in.doy     = g_ff.doy;
      h_in.year    = g_ff.year;
      h_in.hours   = g_ff.hours;
      h_in.minutes = g_ff.minutes;
      h_in.seconds = g_ff.seconds;
   end

   always_comb begin
      mon      = (h_ff.mp < 4'd10) ? h_ff.mp + 4'd3 : h_ff.mp - 4'd9;
      year_adj = h_ff.year + 12'(mon <= 4'd2) - BASE_YEAR;
      dom_full = h_ff.doy - month_start(h_ff.mp) + 9'd1;
      out_res  = '0;
      if (h_ff.win) begin
         out_res.valid_res   = 1'b1;
         out_res.year_offset = year_adj[7:0];
         out_res.month       = mon;
         out_res.day         = dom_full[4:0];
         out_res.hours       = h_ff.hours;
         out_res.minutes     = h_ff.minutes;
         out_res.seconds     = h_ff.seconds;
      end
   end

   assign out_valid = vld_ff[7];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
         d_ff <= d_in;
         e_ff <= e_in;
         f_ff <= f_in;
         g_ff <= g_in;
         h_ff <= h_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/unix_timestamp_to_civil.sv @@
// ----------------------------------------------------------------------------
// unix_timestamp_to_civil
// Unix seconds to Gregorian date (year - 2000, month, day) and hh:mm:ss,
// with an inclusive min/max window that flags out-of-range items.
//
//   channel | dir | handshake            | payload
//   req     | in  | req_tvalid/tready    | tdata: timestamp
//   rsp     | out | rsp_tvalid/tready    | tdata: date/time, tuser: valid_res
//   csr     | in  | csr_valid/csr_ready  | csr_index, csr_data
//
// One item per cycle sustained unless rsp_tready holds the output; an item
// passes the input register, seven arithmetic stages and the output register
// to reach rsp_tvalid. Reset clears all valid bits and loads the default
// window. A result held by rsp_tready low freezes every stage; one more item
// is parked in the input skid register, so req_tready is a flop output.
// ----------------------------------------------------------------------------
`default_nettype none

module unix_timestamp_to_civil
   import utciv_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // [32:0] timestamp, [39:33] zero

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [7:0] year_offset, [11:8] month,
                                         // [16:12] day, [21:17] hours,
                                         // [27:22] minutes, [33:28] seconds,
                                         // [39:34] zero
   output logic [0:0]       rsp_tuser,   // [0] valid_res

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [32:0] csr_data
);

   logic            en;
   logic            req_fire;
   logic            csr_fire;
   logic            skid_full_ff, skid_full_in;
   logic [TS_W-1:0] skid_ts_ff;
   logic [TS_W-1:0] min_ts_ff, min_ts_in;
   logic [TS_W-1:0] max_ts_ff, max_ts_in;
   logic            pipe_in_valid;
   logic [TS_W-1:0] pipe_in_ts;
   logic            pipe_out_valid;
   civil_res_type   pipe_out_res;
   logic            out_vld_ff;
   civil_res_type   out_res_ff;

   assign en         = !out_vld_ff || rsp_tready;
   assign req_tready = !skid_full_ff;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;

   assign pipe_in_valid = skid_full_ff || req_fire;
   assign pipe_in_ts    = skid_full_ff ? skid_ts_ff : req_tdata[TS_W-1:0];

   always_comb begin
      if (skid_full_ff) begin
         skid_full_in = !en;
      end else begin
         skid_full_in = req_fire && !en;
      end
   end

   always_comb begin
      min_ts_in = min_ts_ff;
      max_ts_in = max_ts_ff;
      if (csr_fire) begin
         unique case (csr_index)
            CSR_MIN_TIMESTAMP: min_ts_in = csr_data;
            CSR_MAX_TIMESTAMP: max_ts_in = csr_data;
            default: ;
         endcase
      end
   end

   utciv_pipe u_pipe (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (pipe_in_valid),
      .in_ts     (pipe_in_ts),
      .min_ts    (min_ts_ff),
      .max_ts    (max_ts_ff),
      .out_valid (pipe_out_valid),
      .out_res   (pipe_out_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_full_ff <= 1'b0;
         out_vld_ff   <= 1'b0;
         min_ts_ff    <= MIN_TS_RESET;
         max_ts_ff    <= MAX_TS_RESET;
      end else begin
         skid_full_ff <= skid_full_in;
         min_ts_ff    <= min_ts_in;
         max_ts_ff    <= max_ts_in;
         if (en) begin
            out_vld_ff <= pipe_out_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire && !en) begin
         skid_ts_ff <= req_tdata[TS_W-1:0];
      end
      if (en) begin
         out_res_ff <= pipe_out_res;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tuser  = out_res_ff.valid_res;
   assign rsp_tdata  = {6'd0, out_res_ff.seconds, out_res_ff.minutes, out_res_ff.hours,
                        out_res_ff.day, out_res_ff.month, out_res_ff.year_offset};

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && en |=> !skid_full_ff)
      else $error("skid item not drained when pipeline advanced");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_full_ff && !en |=> skid_full_ff && $stable(skid_ts_ff))
      else $error("parked item lost during stall");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("out-of-window item carries nonzero fields");

   a_valid_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> out_res_ff.month >= 4'd1 && out_res_ff.month <= 4'd12
         && out_res_ff.day >= 5'd1 && out_res_ff.hours <= 5'd23
         && out_res_ff.minutes <= 6'd59 && out_res_ff.seconds <= 6'd59)
      else $error("date/time field out of range");

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for unix_timestamp_to_civil. Timestamps go in on
// the req stream and each result on the rsp stream is checked field by field
// against a date predictor running the era-based days-to-civil conversion.
// Several min/max windows are tried (reset, full, empty, a single second,
// random), with random sender and receiver idling and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import utciv_pkg::*;

   localparam logic [1:0]      CSR_SPARE_A  = 2'd2;
   localparam logic [1:0]      CSR_SPARE_B  = 2'd3;
   localparam logic [TS_W-1:0] TS_MAX       = 33'h1_FFFF_FFFF;
   localparam int              SEG_ITEMS    = 305;
   localparam int              STALL_CYCLES = 80;
   localparam int              IDLE_LIMIT   = 4000;

   class civil_scoreboard;
      logic [TS_W-1:0] win_lo = MIN_TS_RESET;
      logic [TS_W-1:0] win_hi = MAX_TS_RESET;
      civil_res_type   pending[$];
      int              errors;
      int              n_in_window;
      int              n_out_window;
      int              n_checked;

      function void set_reg(logic [1:0] idx, logic [TS_W-1:0] val);
         if (idx == CSR_MIN_TIMESTAMP) begin
            win_lo = val;
         end else if (idx == CSR_MAX_TIMESTAMP) begin
            win_hi = val;
         end
      endfunction

      function civil_res_type to_civil(logic [TS_W-1:0] ts);
         civil_res_type   r;
         longint unsigned days, sod, era, doe, yoe, yr, doy, mp, mon;
         r = '0;
         if (ts < win_lo || ts > win_hi) begin
            return r;
         end
         days = longint'(ts) / 86400 + 719468;
         sod  = longint'(ts) % 86400;
         era  = days / 146097;
         doe  = days - era * 146097;
         yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         yr   = yoe + era * 400;
         doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp   = (5 * doy + 2) / 153;
         mon  = (mp < 10) ? mp + 3 : mp - 9;
         if (mon <= 2) begin
            yr++;
         end
         r.valid_res   = 1'b1;
         r.year_offset = 8'(yr - 2000);
         r.month       = 4'(mon);
         r.day         = 5'(doy - (153 * mp + 2) / 5 + 1);
         r.hours       = 5'(sod / 3600);
         r.minutes     = 6'((sod % 3600) / 60);
         r.seconds     = 6'(sod % 60);
         return r;
      endfunction

      function void note(logic [TS_W-1:0] ts);
         civil_res_type r;
         r = to_civil(ts);
         if (r.valid_res) begin
            n_in_window++;
         end else begin
            n_out_window++;
         end
         pending.push_back(r);
      endfunction

      function void compare(string name, longint unsigned want, longint unsigned got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
         end
      endfunction

      function void check(logic [39:0] data, logic [0:0] flag);
         civil_res_type want;
         if (pending.size() == 0) begin
            $error("result with no item outstanding");
            errors++;
            return;
         end
         want = pending.pop_front();
         n_checked++;
         compare("valid_res", want.valid_res, flag[0]);
         compare("year_offset", want.year_offset, data[7:0]);
         compare("month", want.month, data[11:8]);
         compare("day", want.day, data[16:12]);
         compare("hours", want.hours, data[21:17]);
         compare("minutes", want.minutes, data[27:22]);
         compare("seconds", want.seconds, data[33:28]);
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_tvalid = 1'b0;
   logic            req_tready;
   logic [39:0]     req_tdata = '0;    // [32:0] timestamp
   logic            rsp_tvalid;
   logic            rsp_tready = 1'b0;
   logic [39:0]     rsp_tdata;         // [7:0] year_offset, [11:8] month, [16:12] day,
                                       // [21:17] hours, [27:22] minutes, [33:28] seconds
   logic [0:0]      rsp_tuser;         // [0] valid_res
   logic            csr_valid = 1'b0;
   logic            csr_ready;
   logic [1:0]      csr_index = '0;
   logic [32:0]     csr_data = '0;

   civil_scoreboard sb = new();
   int              snd_idle_pct;
   int              rcv_idle_pct;
   bit              long_stall_req;
   int              idle_cycles;
   int              n_windows;
   logic [TS_W-1:0] cur_lo;
   logic [TS_W-1:0] cur_hi;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   unix_timestamp_to_civil u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // monitor and watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note(req_tdata[TS_W-1:0]);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check(rsp_tdata, rsp_tuser);
         end
         if (csr_valid && csr_ready) begin
            sb.set_reg(csr_index, csr_data);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // receiver: random backpressure plus one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (STALL_CYCLES) @(posedge clock);
         end
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   function automatic logic [TS_W-1:0] rand_ts();
      return TS_W'({$urandom_range(1, 0), $urandom()});
   endfunction

   function automatic logic [TS_W-1:0] rand_between(logic [TS_W-1:0] a, logic [TS_W-1:0] b);
      longint unsigned span;
      span = longint'(b) - longint'(a) + 1;
      return TS_W'(longint'(a) + ({$urandom(), $urandom()} % span));
   endfunction

   task automatic push_item(input logic [TS_W-1:0] ts);
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, ts};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending.size() != 0);
   endtask

   task automatic write_pair(input logic [1:0] ia, input logic [TS_W-1:0] va,
                             input logic [1:0] ib, input logic [TS_W-1:0] vb);
      csr_valid <= 1'b1;
      csr_index <= ia;
      csr_data  <= va;
      do @(posedge clock); while (!csr_ready);
      csr_index <= ib;
      csr_data  <= vb;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_window(input logic [TS_W-1:0] lo, input logic [TS_W-1:0] hi);
      settle();
      write_pair(CSR_MIN_TIMESTAMP, lo, CSR_MAX_TIMESTAMP, hi);
      cur_lo = lo;
      cur_hi = hi;
      n_windows++;
   endtask

   task automatic random_burst(input int count);
      logic [TS_W-1:0] ts;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(9))
            0: ts = rand_ts();
            1: ts = ($urandom_range(1) ? cur_lo : cur_hi) + TS_W'($urandom_range(4)) - 33'd2;
            default: ts = (cur_lo <= cur_hi) ? rand_between(cur_lo, cur_hi) : rand_ts();
         endcase
         push_item(ts);
      end
   endtask

   initial begin
      static logic [TS_W-1:0] dir_reset[$] = '{33'd0, 33'd946684799, 33'd946684800,
                                               33'd951782400, 33'd951868799,
                                               33'd951868800, 33'd1709210096,
                                               33'd4102444799, 33'd4102444800, TS_MAX};
      static logic [TS_W-1:0] dir_full[$]  = '{33'd0, 33'd1, 33'd946684799, 33'd4107542399,
                                               33'd4107542400, 33'd4294967295,
                                               33'd4294967296, TS_MAX};
      static logic [TS_W-1:0] dir_empty[$] = '{33'd946684800, 33'd4102444799, TS_MAX};
      logic [TS_W-1:0] lo, hi, tmp;

      snd_idle_pct = 38;
      rcv_idle_pct = 48;
      cur_lo = MIN_TS_RESET;
      cur_hi = MAX_TS_RESET;
      n_windows = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: reset window, full window, empty window, one-second window
      foreach (dir_reset[i]) push_item(dir_reset[i]);
      set_window(33'd0, TS_MAX);
      foreach (dir_full[i]) push_item(dir_full[i]);
      set_window(TS_MAX, 33'd946684800);
      foreach (dir_empty[i]) push_item(dir_empty[i]);
      set_window(33'd1234567890, 33'd1234567890);
      write_pair(CSR_SPARE_A, 33'd0, CSR_SPARE_B, TS_MAX);
      push_item(33'd1234567889);
      push_item(33'd1234567890);
      push_item(33'd1234567891);

      // random segments, two per idling mode
      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: begin lo = MIN_TS_RESET; hi = MAX_TS_RESET; end
            1: begin lo = 33'd946684800; hi = TS_MAX; end
            2: begin lo = 33'd0; hi = rand_between(33'd946684800, TS_MAX); end
            3: begin
               lo = rand_between(33'd946684800, TS_MAX);
               hi = rand_between(33'd946684800, TS_MAX);
               if (lo > hi) begin
                  tmp = lo;
                  lo  = hi;
                  hi  = tmp;
               end
            end
            4: begin
               lo = rand_between(33'd946684800, TS_MAX - 33'd100000);
               hi = lo + TS_W'($urandom_range(100000));
            end
            default: begin lo = 33'd0; hi = TS_MAX; end
         endcase
         set_window(lo, hi);
         if (seg == 2) begin
            snd_idle_pct = 48;
            rcv_idle_pct = 38;
         end else if (seg == 4) begin
            snd_idle_pct = 0;
            rcv_idle_pct = 0;
         end
         if (seg == 0) begin
            long_stall_req = 1'b1;
         end
         random_burst(SEG_ITEMS);
      end

      settle();
      repeat (20) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d results never arrived", sb.pending.size());
      end
      $display("Checked %0d conversions (%0d inside the window, %0d outside) over %0d windows",
               sb.n_checked, sb.n_in_window, sb.n_out_window, n_windows);
      $display("Idling 38/48 then 48/38 then none, with one %0d-cycle output stall",
               STALL_CYCLES);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
